/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the sorted priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and the priority relation of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PUSH = 2'd0;
    localparam t_kind KIND_POP  = 2'd1;
    localparam t_kind KIND_PEEK = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    localparam int unsigned OCC_W = 5;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_state;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_entry;

    typedef struct packed {
        logic   vld;
        logic   srch;
        t_entry ent;
    } t_wave;

    typedef struct packed {
        logic pop;
        logic order_mode;
    } t_chain_ctrl;

    typedef struct packed {
        logic signed [31:0] front_value;
        logic signed [31:0] front_priority;
        t_status            status;
        logic [OCC_W-1:0]   occupancy;
        logic               is_empty;
    } t_rsp;

    function automatic logic prio_rel(logic signed [31:0] a, logic signed [31:0] b,
                                      logic mode);
        return mode ? (a >= b) : (a <= b);
    endfunction

endpackage

/* rtl/spq_in_if.sv */
// ----------------------------------------------------------------------------
// spq_in_if
// Command channel: push, pop or peek transactions with valid/ready.
// ----------------------------------------------------------------------------
interface spq_in_if import spq_pkg::*; ();

    logic               valid;
    logic               ready;
    t_kind              kind;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;

    modport source (output valid, kind, item_value, item_priority, input ready);
    modport sink   (input valid, kind, item_value, item_priority, output ready);

endinterface

/* rtl/spq_out_if.sv */
// ----------------------------------------------------------------------------
// spq_out_if
// Response channel: one result transaction per command, valid/ready.
// ----------------------------------------------------------------------------
interface spq_out_if import spq_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic signed [31:0]   front_value;
    logic signed [31:0]   front_priority;
    t_status              status;
    logic [OCC_W-1:0]     occupancy;
    logic                 is_empty;

    modport source (output valid, front_value, front_priority, status, occupancy,
                    is_empty, input ready);
    modport sink   (input valid, front_value, front_priority, status, occupancy,
                    is_empty, output ready);

endinterface

/* rtl/sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue of (value, priority) entries kept sorted in a chain
// of cells.
// ----------------------------------------------------------------------------
// Pop, peek, a refused push and an unused command are each done in the cycle
// in which they are accepted. On a push the new entry is registered on
// acceptance, reaches cell 0 in the next cycle and travels one cell per
// cycle, each cell either keeping its entry or swapping it for the travelling
// one, until the wave reaches the first free cell; no command is taken while
// that wave runs. Every result is held in an output register, so a new
// command is taken while the previous result is still waiting, as long as
// that result is taken in the same cycle or the register is empty. The order
// mode register may be written only while no command is in progress.
`include "assert_macros.svh"

module sorted_priority_queue_unit import spq_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    spq_in_if.sink    i_cmd,
    spq_out_if.source o_rsp
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic             r_order_mode;
    logic             w_pop;
    logic [CNT_W-1:0] w_count;
    t_chain_ctrl      w_chain_ctrl;
    t_wave            w_wave [CAPACITY+1];
    t_entry           w_ent  [CAPACITY+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_order_mode <= i_cfg_wdata;
        end
    end

    assign w_chain_ctrl = '{pop: w_pop, order_mode: r_order_mode};

    spq_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .o_rsp    (o_rsp),
        .i_front  (w_ent[0]),
        .o_pop    (w_pop),
        .o_launch (w_wave[0]),
        .o_count  (w_count)
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        spq_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_chain_ctrl),
            .i_count    (w_count),
            .i_wave     (w_wave[k]),
            .o_wave     (w_wave[k+1]),
            .i_next_ent (w_ent[k+1]),
            .o_ent      (w_ent[k])
        );
    end

    // last cell refills from itself on a pop
    assign w_ent[CAPACITY] = w_ent[CAPACITY-1];

    `SPQ_ASSERT(a_no_spill, i_clk, i_rst_n, !w_wave[CAPACITY].vld, "entry shifted past the last cell")

endmodule

/* rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: holds an entry, takes part in the insertion wave and in
// the left shift of a pop.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_cell import spq_pkg::*; #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_chain_ctrl      i_ctrl,
    input  logic [CNT_W-1:0] i_count,
    input  t_wave            i_wave,
    output t_wave            o_wave,
    input  t_entry           i_next_ent,
    output t_entry           o_ent
);

    localparam logic [CNT_W-1:0] L_IDX  = CNT_W'(IDX);
    localparam bit               L_HEAD = (IDX == 0);

    t_entry r_ent, n_ent;
    t_wave  r_wave, n_wave;
    logic   w_occupied;
    logic   w_ins_here;

    assign w_occupied = (L_IDX < i_count);
    assign w_ins_here = L_HEAD ? prio_rel(i_wave.ent.prio, r_ent.prio, i_ctrl.order_mode)
                               : !prio_rel(r_ent.prio, i_wave.ent.prio, i_ctrl.order_mode);

    always_comb begin
        n_ent       = r_ent;
        n_wave.vld  = 1'b0;
        n_wave.srch = 1'b0;
        n_wave.ent  = r_ent;
        priority if (i_ctrl.pop) begin
            n_ent = i_next_ent;
        end else if (i_wave.vld && !w_occupied) begin
            n_ent = i_wave.ent;
        end else if (i_wave.vld && i_wave.srch && !w_ins_here) begin
            n_wave.vld  = 1'b1;
            n_wave.srch = 1'b1;
            n_wave.ent  = i_wave.ent;
        end else if (i_wave.vld) begin
            n_ent       = i_wave.ent;
            n_wave.vld  = 1'b1;
            n_wave.srch = 1'b0;
            n_wave.ent  = r_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave.vld <= 1'b0;
        end else begin
            r_wave <= n_wave;
        end
    end

    assign o_wave = r_wave;
    assign o_ent  = r_ent;

    `SPQ_ASSERT(a_no_pop_in_wave, i_clk, i_rst_n, !(i_ctrl.pop && i_wave.vld), "pop during insertion")

endmodule

/* rtl/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Command decode, occupancy count, insertion wave launch and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_ctrl import spq_pkg::*; #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned CNT_W    = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    spq_in_if.sink           i_cmd,
    spq_out_if.source        o_rsp,
    input  t_entry           i_front,
    output logic             o_pop,
    output t_wave            o_launch,
    output logic [CNT_W-1:0] o_count
);

    localparam logic [CNT_W-1:0] L_CAP = CNT_W'(CAPACITY);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_step, n_step;
    t_wave            r_launch, n_launch;
    logic             r_rsp_vld, n_rsp_vld;
    t_rsp             r_rsp, n_rsp;

    logic w_ready;
    logic w_accept;
    logic w_full;
    logic w_empty;
    logic w_is_push;
    logic w_is_pop;
    logic w_is_peek;
    logic w_do_push;
    logic w_do_pop;
    logic w_wave_done;

    // decode
    always_comb begin
        w_is_push = 1'b0;
        w_is_pop  = 1'b0;
        w_is_peek = 1'b0;
        unique case (i_cmd.kind)
            KIND_PUSH: w_is_push = 1'b1;
            KIND_POP:  w_is_pop  = 1'b1;
            KIND_PEEK: w_is_peek = 1'b1;
            default: ;
        endcase
    end

    assign w_full      = (r_count == L_CAP);
    assign w_empty     = (r_count == '0);
    assign w_accept    = i_cmd.valid && w_ready;
    assign w_do_push   = w_accept && w_is_push && !w_full;
    assign w_do_pop    = w_accept && w_is_pop && !w_empty;
    assign w_wave_done = (r_state == S_BUSY) && (r_step == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_do_push) begin
                n_state = S_BUSY;
            end
            S_BUSY: if (w_wave_done) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_ready = 1'b0;
        unique case (r_state)
            S_IDLE:  w_ready = !r_rsp_vld || o_rsp.ready;
            S_BUSY:  w_ready = 1'b0;
            default: w_ready = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_wave_done) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop) begin
            n_count = r_count - 1'b1;
        end
        n_step = (r_state == S_BUSY) ? r_step + 1'b1 : '0;
        n_launch.vld       = w_do_push;
        n_launch.srch      = 1'b1;
        n_launch.ent.value = i_cmd.item_value;
        n_launch.ent.prio  = i_cmd.item_priority;
    end

    always_comb begin
        n_rsp.front_value    = '0;
        n_rsp.front_priority = '0;
        n_rsp.status         = STAT_OK;
        n_rsp.occupancy      = OCC_W'(r_count);
        if (w_is_push && w_full) begin
            n_rsp.status = STAT_FULL;
        end else if (w_is_push) begin
            n_rsp.occupancy = OCC_W'(r_count + 1'b1);
        end else if ((w_is_pop || w_is_peek) && w_empty) begin
            n_rsp.status = STAT_EMPTY;
        end else if (w_is_pop || w_is_peek) begin
            n_rsp.front_value    = i_front.value;
            n_rsp.front_priority = i_front.prio;
            if (w_is_pop) begin
                n_rsp.occupancy = OCC_W'(r_count - 1'b1);
            end
        end
        n_rsp.is_empty = (n_rsp.occupancy == '0);
        n_rsp_vld = w_accept ? 1'b1 : (o_rsp.ready ? 1'b0 : r_rsp_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_step       <= '0;
            r_launch.vld <= 1'b0;
            r_rsp_vld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_step    <= n_step;
            r_launch  <= n_launch;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign i_cmd.ready          = w_ready;
    assign o_rsp.valid          = r_rsp_vld;
    assign o_rsp.front_value    = r_rsp.front_value;
    assign o_rsp.front_priority = r_rsp.front_priority;
    assign o_rsp.status         = r_rsp.status;
    assign o_rsp.occupancy      = r_rsp.occupancy;
    assign o_rsp.is_empty       = r_rsp.is_empty;
    assign o_pop                = w_do_pop;
    assign o_launch             = r_launch;
    assign o_count              = r_count;

    `SPQ_ASSERT_NEXT(a_pop_dec, i_clk, i_rst_n, w_do_pop, r_count == $past(r_count) - 1'b1, "pop count")
    `SPQ_ASSERT_NEXT(a_push_launch, i_clk, i_rst_n, w_do_push, (r_state == S_BUSY) && r_launch.vld && (r_step == '0), "push launch")
    `SPQ_ASSERT_NEXT(a_wave_end, i_clk, i_rst_n, w_wave_done, (r_state == S_IDLE) && (r_count == $past(r_count) + 1'b1), "wave end")
    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= L_CAP, "count overflow")

endmodule
